// File: hdl/i2cm_pkg.sv
// Shared types and codes for the I2C EEPROM master sequencer.
package i2cm_pkg;

   localparam logic [1:0] CMD_TICK        = 2'd0;
   localparam logic [1:0] CMD_START_READ  = 2'd1;
   localparam logic [1:0] CMD_START_WRITE = 2'd2;
   localparam logic [1:0] CMD_NEXT_BYTE   = 2'd3;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_PHASE_TICKS    = 1'b1;

   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd81;
   localparam logic [15:0] PHASE_TICKS_RESET    = 16'd125;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   typedef enum logic [4:0] {
      SEQ_IDLE    = 5'd0,
      SEQ_START   = 5'd1,
      SEQ_DEVW    = 5'd2,
      SEQ_MEMA    = 5'd3,
      SEQ_RESTART = 5'd4,
      SEQ_DEVR    = 5'd5,
      SEQ_READ    = 5'd6,
      SEQ_WAIT    = 5'd7,
      SEQ_WDATA   = 5'd8,
      SEQ_STOP    = 5'd9
   } seq_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] mem_address;
      logic [7:0] byte_count;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_released;
      logic [7:0] rx_byte;
      logic       read_valid;
      logic       data_request;
      logic       done_res;
      logic       nacked;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] phase_ticks;
   } cfg_type;

endpackage

// File: hdl/i2cm_csr.sv
// Configuration registers: device address and quarter-slot length.
module i2cm_csr
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   logic [6:0]  device_address_ff;
   logic [15:0] phase_ticks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         phase_ticks_ff    <= PHASE_TICKS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_data[6:0];
            CSR_PHASE_TICKS:    phase_ticks_ff    <= csr_data;
            default:            ;
         endcase
      end
   end

   assign cfg.device_address = device_address_ff;
   assign cfg.phase_ticks    = phase_ticks_ff;

endmodule

// File: hdl/i2cm_seq.sv
// Bus sequencer: state registers, one-step next-state logic and pin drive.
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   seq_state_type state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [15:0]   tick_ff, tick_in;
   logic [3:0]    bit_ff, bit_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    left_ff, left_in;
   logic [7:0]    held_addr_ff, held_addr_in;
   logic          read_mode_ff, read_mode_in;
   logic          nack_ff, nack_in;

   logic          rvalid;
   logic [7:0]    rbyte;
   logic          done;
   logic          scl;
   logic          sda;

   // next state
   always_comb begin
      logic [16:0] count;
      logic [16:0] len;
      logic [7:0]  sh;
      logic [7:0]  left_dec;
      state_in     = state_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      held_addr_in = held_addr_ff;
      read_mode_in = read_mode_ff;
      nack_in      = nack_ff;
      rvalid       = 1'b0;
      rbyte        = 8'd0;
      done         = 1'b0;
      count        = {1'b0, tick_ff} + 17'd1;
      len          = (cfg.phase_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.phase_ticks};
      sh           = shift_ff;
      left_dec     = left_ff - 8'd1;
      if (advance) begin
         priority if ((item.command == CMD_START_READ || item.command == CMD_START_WRITE)
                      && state_ff == SEQ_IDLE) begin
            read_mode_in = (item.command == CMD_START_READ);
            held_addr_in = item.mem_address;
            left_in      = (item.command == CMD_START_READ && item.byte_count == 8'd0)
                           ? 8'd1 : item.byte_count;
            nack_in      = 1'b0;
            state_in     = SEQ_START;
            shift_in     = 8'd0;
            bit_in       = 4'd0;
            phase_in     = 2'd0;
            tick_in      = 16'd0;
         end else if (item.command == CMD_NEXT_BYTE && state_ff == SEQ_WAIT) begin
            state_in = SEQ_WDATA;
            shift_in = item.write_data;
            bit_in   = 4'd0;
            phase_in = 2'd0;
            tick_in  = 16'd0;
         end else if (state_ff != SEQ_IDLE && state_ff != SEQ_WAIT) begin
            if (count < len) begin
               tick_in = count[15:0];
            end else begin
               tick_in = 16'd0;
               // sample data line at end of q2
               if (phase_ff == 2'd2) begin
                  if (state_ff == SEQ_READ) begin
                     if (bit_ff < 4'd8) sh = {shift_ff[6:0], item.sda_in};
                  end else if (bit_ff == 4'd8) begin
                     sh = {7'd0, item.sda_in};
                  end
               end
               shift_in = sh;
               if (phase_ff != 2'd3) begin
                  phase_in = phase_ff + 2'd1;
               end else begin
                  phase_in = 2'd0;
                  unique case (state_ff)
                     SEQ_START: begin
                        state_in = SEQ_DEVW;
                        shift_in = {cfg.device_address, RW_WRITE};
                        bit_in   = 4'd0;
                     end
                     SEQ_RESTART: begin
                        state_in = SEQ_DEVR;
                        shift_in = {cfg.device_address, RW_READ};
                        bit_in   = 4'd0;
                     end
                     SEQ_DEVW, SEQ_MEMA, SEQ_DEVR, SEQ_WDATA: begin
                        if (bit_ff < 4'd8) begin
                           shift_in = {sh[6:0], 1'b0};
                           bit_in   = bit_ff + 4'd1;
                        end else begin
                           shift_in = 8'd0;
                           bit_in   = 4'd0;
                           priority if (sh[0]) begin
                              nack_in  = 1'b1;
                              state_in = SEQ_STOP;
                           end else if (state_ff == SEQ_DEVW) begin
                              state_in = SEQ_MEMA;
                              shift_in = held_addr_ff;
                           end else if (state_ff == SEQ_MEMA) begin
                              priority if (read_mode_ff)      state_in = SEQ_RESTART;
                              else if (left_ff == 8'd0)       state_in = SEQ_STOP;
                              else                            state_in = SEQ_WAIT;
                           end else if (state_ff == SEQ_DEVR) begin
                              state_in = SEQ_READ;
                           end else begin
                              left_in  = left_dec;
                              state_in = (left_dec == 8'd0) ? SEQ_STOP : SEQ_WAIT;
                           end
                        end
                     end
                     SEQ_READ: begin
                        if (bit_ff < 4'd8) begin
                           if (bit_ff == 4'd7) begin
                              rvalid = 1'b1;
                              rbyte  = sh;
                           end
                           bit_in = bit_ff + 4'd1;
                        end else begin
                           if (left_ff != 8'd0) left_in = left_dec;
                           // last byte when count was one or zero
                           state_in = (left_ff <= 8'd1) ? SEQ_STOP : SEQ_READ;
                           shift_in = 8'd0;
                           bit_in   = 4'd0;
                        end
                     end
                     SEQ_STOP: begin
                        state_in = SEQ_IDLE;
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                        done     = 1'b1;
                     end
                     default: begin
                        state_in = SEQ_IDLE;
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                     end
                  endcase
               end
            end
         end else begin
            // idle, or waiting for data without it: the beat changes nothing
         end
      end
   end

   // pin drive from the updated state
   always_comb begin
      scl = 1'b1;
      sda = 1'b1;
      unique case (state_in)
         SEQ_START, SEQ_RESTART: begin
            scl = (phase_in == 2'd1 || phase_in == 2'd2);
            sda = (phase_in < 2'd2);
         end
         SEQ_STOP: begin
            scl = (phase_in != 2'd0);
            sda = phase_in[1];
         end
         SEQ_DEVW, SEQ_MEMA, SEQ_DEVR, SEQ_WDATA: begin
            scl = phase_in[1];
            sda = (bit_in < 4'd8) ? shift_in[7] : 1'b1;
         end
         SEQ_READ: begin
            scl = phase_in[1];
            sda = (bit_in < 4'd8) ? 1'b1 : !(left_in > 8'd1);
         end
         SEQ_WAIT: begin
            scl = 1'b0;
            sda = 1'b1;
         end
         default: begin
            scl = 1'b1;
            sda = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         phase_ff     <= 2'd0;
         tick_ff      <= 16'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         left_ff      <= 8'd0;
         held_addr_ff <= 8'd0;
         read_mode_ff <= 1'b0;
         nack_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         held_addr_ff <= held_addr_in;
         read_mode_ff <= read_mode_in;
         nack_ff      <= nack_in;
      end
   end

   assign result.scl_level    = scl;
   assign result.sda_released = sda;
   assign result.rx_byte      = rbyte;
   assign result.read_valid   = rvalid;
   assign result.data_request = (state_in == SEQ_WAIT);
   assign result.done_res     = done;
   assign result.nacked       = nack_in;
   assign result.busy_res     = (state_in != SEQ_IDLE);

endmodule

// File: hdl/i2c_master_random_read_page_write.sv
// Top level of the I2C EEPROM master: input stage, sequencer, result register.
//
//   channel   dir   beat            handshake
//   req_      in    req_type        req_valid / req_ready
//   rsp_      out   rsp_type        rsp_valid / rsp_ready
//   csr_      in    index + data    csr_valid / csr_ready (always ready)
//
// One result beat per request beat. A request is registered in the input
// register and is worked into the sequencer and the result register as the
// result slot frees up, at one beat per cycle while rsp_ready stays high.
// Throughput is set only by the result register draining: while rsp_ready
// is low the input register holds one beat and req_ready drops.
// Reset is synchronous; it empties both stages and returns the bus to idle.
module i2c_master_random_read_page_write
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg;
   rsp_type result;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic    advance;

   // the sequencer steps when an item waits and the result slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a stepped beat always lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("stepped beat not presented");

   // a held input beat is never dropped
   a_input_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input beat lost");

   // a new beat enters a full input stage only as the old one moves on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && in_valid_ff) |-> advance)
      else $error("input stage overwritten");

   // stop completion leaves the bus idle with both lines high
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && result.done_res) |=>
      (!rsp_data.busy_res && rsp_data.scl_level && rsp_data.sda_released))
      else $error("stop completed but bus not idle");

endmodule

// File: tb/i2c_master_random_read_page_write_tb.sv
// Self-checking testbench for the I2C EEPROM master: random reads, page writes, target acks.
module i2c_master_random_read_page_write_tb;
   import i2cm_pkg::*;

   // Run limit, far above the slowest legal run of this stimulus.
   localparam int CYCLE_LIMIT  = 600000;
   localparam int NEVER_REFUSE = 32'h3FFF_FFFF;

   // How the emulated target answers the ack slot of a beat.
   localparam logic [1:0] TGT_ACK  = 2'd0;  // pulls SDA low on every ack slot
   localparam logic [1:0] TGT_NACK = 2'd1;  // leaves SDA high on every ack slot
   localparam logic [1:0] TGT_WILD = 2'd2;  // SDA exactly as generated

   // Receiver stall patterns.
   localparam int RX_OPEN     = 0;
   localparam int RX_CHOPPY   = 1;
   localparam int RX_MOSTLY   = 2;
   localparam int RX_SLUGGISH = 3;

   typedef struct {
      req_type    req;
      logic [1:0] target;
   } pend_item_type;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_DEVICE_ADDRESS;
   logic [15:0] csr_data  = '0;

   initial forever #6 clock = ~clock;

   i2c_master_random_read_page_write i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------
   // Bus sequencer prediction. Own copy of the config and of every
   // sequencer register; one call per accepted request beat.
   // ---------------------------------------------------------------------
   logic [6:0]    cfg_dev;
   logic [15:0]   cfg_phase;

   seq_state_type seq_now;
   logic [1:0]    quarter;
   logic [15:0]   tick_cnt;
   logic [3:0]    bit_no;
   logic [7:0]    shreg;
   logic [7:0]    left;
   logic [7:0]    mem_addr_q;
   logic          is_read;
   logic          refused;
   logic          scl_q;
   logic          sda_q;
   logic          got_byte;
   logic [7:0]    got_value;
   logic          stop_done;

   function automatic void sequencer_reset();
      cfg_dev    = DEVICE_ADDRESS_RESET;
      cfg_phase  = PHASE_TICKS_RESET;
      seq_now    = SEQ_IDLE;
      quarter    = '0;
      tick_cnt   = '0;
      bit_no     = '0;
      shreg      = '0;
      left       = '0;
      mem_addr_q = '0;
      is_read    = 1'b0;
      refused    = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
   endfunction

   function automatic void slot_begin(seq_state_type st, logic [7:0] sh);
      seq_now  = st;
      shreg    = sh;
      bit_no   = '0;
      quarter  = '0;
      tick_cnt = '0;
   endfunction

   // End of the fourth quarter: next bit, next byte or next bus condition.
   function automatic void slot_end();
      case (seq_now)
         SEQ_START:   slot_begin(SEQ_DEVW, {cfg_dev, RW_WRITE});
         SEQ_RESTART: slot_begin(SEQ_DEVR, {cfg_dev, RW_READ});
         SEQ_DEVW, SEQ_MEMA, SEQ_DEVR, SEQ_WDATA: begin
            if (bit_no < 4'd8) begin
               shreg  = {shreg[6:0], 1'b0};
               bit_no = bit_no + 4'd1;
            end else if (shreg[0]) begin
               // target did not ack: stop and flag it
               refused = 1'b1;
               slot_begin(SEQ_STOP, 8'd0);
            end else if (seq_now == SEQ_DEVW) begin
               slot_begin(SEQ_MEMA, mem_addr_q);
            end else if (seq_now == SEQ_MEMA) begin
               if (is_read)          slot_begin(SEQ_RESTART, 8'd0);
               else if (left == '0)  slot_begin(SEQ_STOP, 8'd0);
               else                  slot_begin(SEQ_WAIT, 8'd0);
            end else if (seq_now == SEQ_DEVR) begin
               slot_begin(SEQ_READ, 8'd0);
            end else begin
               left = left - 8'd1;
               if (left == '0) slot_begin(SEQ_STOP, 8'd0);
               else            slot_begin(SEQ_WAIT, 8'd0);
            end
         end
         SEQ_READ: begin
            if (bit_no < 4'd8) begin
               if (bit_no == 4'd7) begin
                  got_byte  = 1'b1;
                  got_value = shreg;
               end
               bit_no = bit_no + 4'd1;
            end else begin
               if (left != '0) left = left - 8'd1;
               if (left == '0) slot_begin(SEQ_STOP, 8'd0);
               else            slot_begin(SEQ_READ, 8'd0);
            end
         end
         SEQ_STOP: begin
            slot_begin(SEQ_IDLE, 8'd0);
            stop_done = 1'b1;
         end
         default: slot_begin(SEQ_IDLE, 8'd0);
      endcase
   endfunction

   function automatic void advance_tick(logic sda);
      logic [16:0] span;
      logic [16:0] cnt_next;
      span     = (cfg_phase == '0) ? 17'd1 : {1'b0, cfg_phase};
      cnt_next = {1'b0, tick_cnt} + 17'd1;
      if (cnt_next < span) begin
         tick_cnt = cnt_next[15:0];
         return;
      end
      tick_cnt = '0;
      // SDA is sampled at the end of the third quarter
      if (quarter == 2'd2) begin
         if (seq_now == SEQ_READ) begin
            if (bit_no < 4'd8) shreg = {shreg[6:0], sda};
         end else if (bit_no == 4'd8) begin
            shreg = {7'd0, sda};
         end
      end
      if (quarter == 2'd3) begin
         quarter = '0;
         slot_end();
      end else begin
         quarter = quarter + 2'd1;
      end
   endfunction

   function automatic void bus_drive();
      case (seq_now)
         SEQ_START, SEQ_RESTART: begin
            scl_q = (quarter == 2'd1 || quarter == 2'd2);
            sda_q = (quarter < 2'd2);
         end
         SEQ_STOP: begin
            scl_q = (quarter != 2'd0);
            sda_q = quarter[1];
         end
         SEQ_DEVW, SEQ_MEMA, SEQ_DEVR, SEQ_WDATA: begin
            scl_q = quarter[1];
            sda_q = (bit_no < 4'd8) ? shreg[7] : 1'b1;
         end
         SEQ_READ: begin
            // master acks every byte but the last
            scl_q = quarter[1];
            sda_q = (bit_no < 4'd8) ? 1'b1 : !(left > 8'd1);
         end
         SEQ_WAIT: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
         end
         default: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
      endcase
   endfunction

   function automatic rsp_type sequencer_step(req_type rq);
      rsp_type r;
      got_byte  = 1'b0;
      got_value = '0;
      stop_done = 1'b0;
      if ((rq.command == CMD_START_READ || rq.command == CMD_START_WRITE) &&
          seq_now == SEQ_IDLE) begin
         is_read    = (rq.command == CMD_START_READ);
         mem_addr_q = rq.mem_address;
         left       = (is_read && rq.byte_count == '0) ? 8'd1 : rq.byte_count;
         refused    = 1'b0;
         slot_begin(SEQ_START, 8'd0);
      end else if (rq.command == CMD_NEXT_BYTE && seq_now == SEQ_WAIT) begin
         slot_begin(SEQ_WDATA, rq.write_data);
      end else if (seq_now != SEQ_IDLE && seq_now != SEQ_WAIT) begin
         advance_tick(rq.sda_in);
      end
      bus_drive();
      r.scl_level    = scl_q;
      r.sda_released = sda_q;
      r.rx_byte      = got_byte ? got_value : 8'd0;
      r.read_valid   = got_byte;
      r.data_request = (seq_now == SEQ_WAIT);
      r.done_res     = stop_done;
      r.nacked       = refused;
      r.busy_res     = (seq_now != SEQ_IDLE);
      return r;
   endfunction

   // Emulated target: answers the ack slot from the predicted bus position.
   function automatic req_type with_target_sda(pend_item_type p);
      req_type rq;
      rq = p.req;
      if (p.target != TGT_WILD && bit_no == 4'd8 &&
          (seq_now == SEQ_DEVW || seq_now == SEQ_MEMA ||
           seq_now == SEQ_DEVR || seq_now == SEQ_WDATA))
         rq.sda_in = (p.target == TGT_NACK);
      return rq;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps. The beat's SDA
   // is settled when it goes on the bus; the prediction is up to date then
   // since beats are accepted in order.
   // ---------------------------------------------------------------------
   pend_item_type cmd_backlog[$];
   rsp_type       pins_due[$];
   int            beats_sent;
   int            burst_left;
   int            gap_left;
   pend_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            pins_due.push_back(sequencer_step(req_data));
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0 || cmd_backlog.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_item = cmd_backlog.pop_front();
               req_data  <= with_target_sda(next_item);
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  gap_left   = $urandom_range(1, 6);
                  // some long bursts give stretches with no idling at all
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 20);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: changing stall patterns, plus one long hold-off while
   // the backlog is deep so both stages fill and req_ready drops.
   // ---------------------------------------------------------------------
   int hold_left;
   int pattern_left;
   int pattern_kind;
   bit held_once;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         hold_left    = 0;
         pattern_left = 0;
         pattern_kind = RX_OPEN;
         held_once    = 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!held_once && beats_sent > 400 && cmd_backlog.size() > 100) begin
         held_once = 1'b1;
         hold_left = 150;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_kind = $urandom_range(RX_OPEN, RX_SLUGGISH);
            pattern_left = $urandom_range(20, 200);
         end
         pattern_left--;
         case (pattern_kind)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:   rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   int      fail_count;
   int      bytes_read;
   int      stops_seen;
   int      refusals_seen;
   rsp_type due;

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pins_due.size() == 0) begin
            $error("result beat with no request outstanding");
            fail_count++;
         end else begin
            due = pins_due.pop_front();
            check_field("scl_level",    32'(due.scl_level),    32'(rsp_data.scl_level));
            check_field("sda_released", 32'(due.sda_released), 32'(rsp_data.sda_released));
            check_field("rx_byte",      32'(due.rx_byte),      32'(rsp_data.rx_byte));
            check_field("read_valid",   32'(due.read_valid),   32'(rsp_data.read_valid));
            check_field("data_request", 32'(due.data_request), 32'(rsp_data.data_request));
            check_field("done_res",     32'(due.done_res),     32'(rsp_data.done_res));
            check_field("nacked",       32'(due.nacked),       32'(rsp_data.nacked));
            check_field("busy_res",     32'(due.busy_res),     32'(rsp_data.busy_res));
            if (due.read_valid) bytes_read++;
            if (due.done_res) stops_seen++;
            if (due.done_res && due.nacked) refusals_seen++;
         end
      end
   end

   // Watchdog
   int cycle_count;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("no completion within %0d cycles", CYCLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   int items_planned;
   int csr_writes;

   // Called at a clock edge; returns at the edge that took the write.
   task automatic csr_write(logic idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DEVICE_ADDRESS) cfg_dev = value[6:0];
      else                           cfg_phase = value;
      csr_writes++;
   endtask

   // Upper data bits on the address write are don't-care and get junk.
   task automatic set_bus(logic [6:0] dev, logic [15:0] span);
      csr_write(CSR_DEVICE_ADDRESS, {9'($urandom), dev});
      csr_write(CSR_PHASE_TICKS, span);
      csr_valid <= 1'b0;
   endtask

   // Wait for every beat to come back, then let the pipeline settle.
   task automatic drain();
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid || pins_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_start(logic [1:0] cmd, logic [7:0] maddr, logic [7:0] count);
      pend_item_type p;
      p.req.command     = cmd;
      p.req.mem_address = maddr;
      p.req.byte_count  = count;
      p.req.write_data  = 8'($urandom);
      p.req.sda_in      = 1'($urandom);
      p.target          = TGT_ACK;
      cmd_backlog.push_back(p);
      items_planned++;
   endtask

   // Tick stream: mostly plain ticks, a quarter data-supply commands (they
   // act as ticks unless the master waits), rare stray starts.
   task automatic queue_ticks(int n, int ack_until, bit wild);
      pend_item_type p;
      int            roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 255);
         if (roll == 0)      p.req.command = CMD_START_READ;
         else if (roll == 1) p.req.command = CMD_START_WRITE;
         else if (roll < 66) p.req.command = CMD_NEXT_BYTE;
         else                p.req.command = CMD_TICK;
         p.req.mem_address = 8'($urandom);
         p.req.byte_count  = (roll < 2) ? 8'($urandom_range(0, 2))
                                        : 8'($urandom_range(0, 255));
         p.req.write_data  = 8'($urandom);
         p.req.sda_in      = 1'($urandom);
         if (wild)               p.target = TGT_WILD;
         else if (i < ack_until) p.target = TGT_ACK;
         else                    p.target = TGT_NACK;
         cmd_backlog.push_back(p);
      end
      items_planned += n;
   endtask

   // One transfer with enough ticks to finish it at the current phase length.
   task automatic queue_txn(logic [1:0] cmd, logic [7:0] maddr, logic [7:0] count,
                            int ack_until, bit wild, int slack);
      int eff;
      int n_bytes;
      int slots;
      int body;
      eff     = (cfg_phase == '0) ? 1 : cfg_phase;
      n_bytes = (count == '0) ? 1 : count;
      if (cmd == CMD_START_READ) slots = 39 + 9 * (n_bytes - 1);
      else                       slots = 20 + 9 * count;
      body = slots * 4 * eff + ((cmd == CMD_START_WRITE) ? 8 * count : 0) + slack;
      if (!wild && ack_until < body && ack_until + 60 * eff < body)
         body = ack_until + 60 * eff;
      if (body < 1) body = 1;
      queue_start(cmd, maddr, count);
      queue_ticks(body, ack_until, wild);
   endtask

   task automatic random_phase(int quota);
      int         mark;
      int         sel;
      int         ack_until;
      int         slack;
      int         eff;
      bit         wild;
      logic [1:0] cmd;
      logic [7:0] count;
      mark = items_planned;
      eff  = (cfg_phase == '0) ? 1 : cfg_phase;
      while (items_planned - mark < quota) begin
         cmd       = $urandom_range(0, 1) ? CMD_START_READ : CMD_START_WRITE;
         sel       = $urandom_range(0, 19);
         ack_until = NEVER_REFUSE;
         wild      = 1'b0;
         if (sel < 15)      count = 8'($urandom_range(0, 3));
         else if (sel < 19) count = 8'($urandom_range(4, 8));
         else               count = 8'($urandom_range(128, 255));
         if (count >= 8'd128) begin
            // long page write cut short by a refused data byte
            cmd       = CMD_START_WRITE;
            ack_until = $urandom_range(90, 220) * eff;
         end else begin
            sel = $urandom_range(0, 19);
            if (sel < 3)      ack_until = $urandom_range(0, 120) * eff;
            else if (sel < 5) wild = 1'b1;
         end
         // now and then too few ticks, so the next start hits a busy master
         slack = ($urandom_range(0, 7) == 0) ? -$urandom_range(1, 30) : $urandom_range(0, 6);
         queue_txn(cmd, 8'($urandom), count, ack_until, wild, slack);
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      sequencer_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset config (phase 125): start a zero-count read, stay in the start slot.
      queue_start(CMD_START_READ, 8'hFF, 8'd0);
      queue_ticks(100, NEVER_REFUSE, 1'b0);
      drain();
      // Shorten the phase mid-slot; the address byte picks up the new device.
      set_bus(7'd127, 16'd1);
      queue_ticks(166, NEVER_REFUSE, 1'b0);

      // Directed transfers at phase 1.
      queue_txn(CMD_START_WRITE, 8'h00, 8'd0, NEVER_REFUSE, 1'b0, 2);  // addresses only
      queue_txn(CMD_START_READ,  8'h10, 8'd1, 0,  1'b0, 2);   // device address refused
      queue_txn(CMD_START_WRITE, 8'hFF, 8'd4, NEVER_REFUSE, 1'b0, -25);
      queue_txn(CMD_START_WRITE, 8'h20, 8'd2, 40, 1'b0, 2);   // memory address refused
      queue_txn(CMD_START_READ,  8'h30, 8'd1, 80, 1'b0, 2);   // read address refused
      drain();

      // Phase 0 behaves as 1; device address 0.
      set_bus(7'd0, 16'd0);
      queue_txn(CMD_START_WRITE, 8'($urandom), 8'd255, 220, 1'b0, 0);
      drain();

      // Longest phase, then cut to 2 while the counter sits far past it.
      set_bus(7'($urandom), 16'hFFFF);
      queue_start(CMD_START_WRITE, 8'($urandom), 8'd1);
      queue_ticks(100, NEVER_REFUSE, 1'b0);
      drain();
      set_bus(7'($urandom), 16'd2);
      queue_ticks(250, NEVER_REFUSE, 1'b0);
      drain();

      // Random traffic.
      set_bus(7'($urandom), 16'd1);
      random_phase(100);
      drain();
      repeat (10) @(posedge clock);

      if (pins_due.size() != 0) begin
         $error("%0d expected result beats never arrived", pins_due.size());
         fail_count++;
      end
      $display("Ran %0d request beats under %0d register writes (phase 0, 1, 2, 125, 65535).",
               beats_sent, csr_writes);
      $display("Bus saw %0d stops, %0d of them after a refused ack, and %0d bytes read.",
               stops_seen, refusals_seen, bytes_read);
      if (fail_count == 0) $display("TEST PASSED");
      else                 $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hdl/i2cm_pkg.sv
hdl/i2cm_csr.sv
hdl/i2cm_seq.sv
hdl/i2c_master_random_read_page_write.sv
tb/i2c_master_random_read_page_write_tb.sv
